// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bte_pkg.sv =====
// ----------------------------------------------------------------------------
// Balanced ternary size encoder package
// Widths, constants and shared types of the encoder.
// ----------------------------------------------------------------------------
package bte_pkg;

  localparam int unsigned MAX_TRYTES = 13;
  localparam int unsigned VALUE_W    = 61;
  localparam int unsigned TRYTE_W    = 5;
  localparam int unsigned COUNT_W    = $clog2(MAX_TRYTES + 1);

  // 27 divides 2^18 - 1 exactly, with quotient 9709.
  localparam int unsigned RECIP_W    = 14;
  localparam int unsigned FOLD_SHIFT = 18;
  localparam int unsigned PROD_W     = VALUE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] TRYTE_RECIP = 14'd9709;

  // Largest digit magnitude, and 32 - 27 for wrapping residues mod 32.
  localparam logic [TRYTE_W-1:0] TRYTE_HALF = 5'd13;
  localparam logic [TRYTE_W-1:0] TRYTE_WRAP = 5'd5;

  typedef logic [VALUE_W-1:0]        value_t;
  typedef logic signed [TRYTE_W-1:0] tryte_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // Largest magnitude held by d balanced trytes: (27^d - 1) / 2.
  localparam value_t TRYTE_LIMIT [MAX_TRYTES+1] = '{
    61'd0,
    61'd13,
    61'd364,
    61'd9841,
    61'd265720,
    61'd7174453,
    61'd193710244,
    61'd5230176601,
    61'd141214768240,
    61'd3812798742493,
    61'd102945566047324,
    61'd2779530283277761,
    61'd75047317648499560,
    61'd2026277576509488133
  };

  // Result of one balanced divide-by-27 step.
  typedef struct packed {
    value_t quot;
    tryte_t digit;
    logic   carry;
  } div_res_t;

endpackage

// ===== sv/bte_if.sv =====
// ----------------------------------------------------------------------------
// Encoder channels
// Valid/ready channels for input values and output trytes.
// ----------------------------------------------------------------------------
interface bte_in_if import bte_pkg::*;;
  logic   valid;
  logic   ready;
  value_t value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface bte_out_if import bte_pkg::*;;
  logic   valid;
  logic   ready;
  tryte_t tryte_out;
  logic   is_header;
  logic   last_tryte;
  logic   range_error;

  modport source (output valid, output tryte_out, output is_header,
                  output last_tryte, output range_error, input ready);
  modport sink   (input valid, input tryte_out, input is_header,
                  input last_tryte, input range_error, output ready);
endinterface

// ===== sv/balanced_ternary_size_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Balanced ternary size encoder core
// Encodes an unsigned value as a length header and balanced base-27 trytes.
// ----------------------------------------------------------------------------
// Each accepted item is a 61-bit unsigned value. The core emits a header
// tryte holding the digit count d (the fewest trytes whose range covers the
// value, at most 13), then d balanced base-27 digits from -13 to 13, least
// significant first; zero gives the header alone, and a value above
// (27^13-1)/2 gives a single item with range_error set. The final item of
// each encoding has last_tryte set. The core takes one value at a time: it
// is ready only when idle, and a stalled output holds it in the header or
// digit states. Each digit comes from the shared divide-by-27 unit, which
// first registers a reciprocal product and then folds it into quotient and
// digit; the first product is formed while the header is written. Results
// pass through an output register, so a waiting result never holds up the
// idle core from taking the next value.

`include "assert_macros.svh"

module balanced_ternary_size_encoder_core import bte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bte_in_if.sink    in_i,
  bte_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIZE,
    ST_MUL,
    ST_FOLD
  } state_e;

  state_e   state_d, state_q;
  value_t   rem_d, rem_q;
  logic     carry_d, carry_q;
  count_t   left_d, left_q;

  logic     out_valid_d, out_valid_q;
  tryte_t   out_tryte_d, out_tryte_q;
  logic     out_hdr_d, out_hdr_q;
  logic     out_last_d, out_last_q;
  logic     out_err_d, out_err_q;

  logic     out_free;
  count_t   size_cnt;
  logic     size_err;
  logic     div_load;
  div_res_t div_res;

  // The output register may take a new item when it is empty or is being
  // emptied in this cycle.
  assign out_free = !out_valid_q || out_o.ready;

  // The digit count is the number of limits that the value exceeds. The
  // thirteen comparisons are against constants and run side by side.
  always_comb begin
    size_cnt = '0;
    for (int k = 0; k < MAX_TRYTES; k++) begin
      size_cnt = size_cnt + count_t'(rem_q > TRYTE_LIMIT[k]);
    end
    size_err = rem_q > TRYTE_LIMIT[MAX_TRYTES];
  end

  // The product for the first digit is formed while the header is written,
  // and later ones in the multiply state before each fold.
  assign div_load = (state_q == ST_SIZE) || (state_q == ST_MUL);

  bte_div27 u_div (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .dividend_i (rem_q),
    .carry_i    (carry_q),
    .res_o      (div_res)
  );

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    carry_d     = carry_q;
    left_d      = left_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_tryte_d = out_tryte_q;
    out_hdr_d   = out_hdr_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rem_d   = in_i.value_in;
          carry_d = 1'b0;
          state_d = ST_SIZE;
        end
      end

      ST_SIZE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (size_err) begin
            // Out of range: a lone flagged item, no header and no digits.
            out_tryte_d = '0;
            out_hdr_d   = 1'b0;
            out_last_d  = 1'b1;
            out_err_d   = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            out_tryte_d = tryte_t'({1'b0, size_cnt});
            out_hdr_d   = 1'b1;
            out_last_d  = (size_cnt == '0);
            out_err_d   = 1'b0;
            left_d      = size_cnt;
            state_d     = (size_cnt == '0) ? ST_IDLE : ST_FOLD;
          end
        end
      end

      ST_MUL: begin
        state_d = ST_FOLD;
      end

      ST_FOLD: begin
        if (out_free) begin
          // A digit above 13 is taken as a negative one, and the borrowed
          // unit rides into the next product as a carry.
          out_valid_d = 1'b1;
          out_tryte_d = div_res.digit;
          out_hdr_d   = 1'b0;
          out_last_d  = (left_q == count_t'(1));
          out_err_d   = 1'b0;
          rem_d       = div_res.quot;
          carry_d     = div_res.carry;
          left_d      = left_q - count_t'(1);
          state_d     = (left_q == count_t'(1)) ? ST_IDLE : ST_MUL;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      carry_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_tryte_q <= '0;
      out_hdr_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      carry_q     <= carry_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
      out_tryte_q <= out_tryte_d;
      out_hdr_q   <= out_hdr_d;
      out_last_q  <= out_last_d;
      out_err_q   <= out_err_d;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.tryte_out   = out_tryte_q;
  assign out_o.is_header   = out_hdr_q;
  assign out_o.last_tryte  = out_last_q;
  assign out_o.range_error = out_err_q;

  // Once a value is taken, no other may enter until its encoding is done.
  `ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "accepted while busy")

  // The fold state is only reached with digits still owed.
  `ASSERT_IMPL(a_fold_has_digits, state_q == ST_FOLD, left_q != '0, "fold with no digits left")

  // A header never announces more digits than the format allows.
  `ASSERT_IMPL(a_header_in_range, out_valid_q && out_hdr_q, (out_tryte_q <= tryte_t'(MAX_TRYTES)) && !out_err_q, "bad header")

endmodule

// ===== sv/bte_div27.sv =====
// ----------------------------------------------------------------------------
// Balanced divide-by-27 unit
// Each step: registered reciprocal product, then fold and digit recode.
// ----------------------------------------------------------------------------
module bte_div27 import bte_pkg::*; (
  input  logic     clk_i,
  input  logic     load_i,
  input  value_t   dividend_i,
  input  logic     carry_i,
  output div_res_t res_o
);

  localparam int unsigned SUM_W = PROD_W + 1;

  logic [PROD_W-1:0]  prod_d, prod_q;
  logic [TRYTE_W-1:0] lo_d, lo_q;
  logic [SUM_W-1:0]   fold_sum;
  logic [TRYTE_W-1:0] rem;
  logic               wrap;

  // The pending carry is added as one more copy of the reciprocal.
  always_comb begin
    prod_d = PROD_W'(dividend_i) * PROD_W'(TRYTE_RECIP)
           + (carry_i ? PROD_W'(TRYTE_RECIP) : '0);
    lo_d   = dividend_i[TRYTE_W-1:0] + TRYTE_W'(carry_i);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      lo_q   <= lo_d;
    end
  end

  // x/27 = P/(2^18-1) = sum of P/2^(18k). The truncated terms only ever
  // pull the sum down by a tiny fraction, so the quotient is exact whenever
  // x is not a multiple of 27. For a multiple of 27 it may come out one low;
  // the remainder then reads 27, which the recode below turns into digit 0
  // with a carry, and the carry restores the quotient in the next step.
  always_comb begin
    fold_sum = SUM_W'(prod_q)
             + SUM_W'(prod_q >> FOLD_SHIFT)
             + SUM_W'(prod_q >> (2 * FOLD_SHIFT))
             + SUM_W'(prod_q >> (3 * FOLD_SHIFT))
             + SUM_W'(prod_q >> (4 * FOLD_SHIFT));
    // Remainder is below 32, so x - 27q = x + 5q mod 32 gives it whole.
    rem  = lo_q + TRYTE_W'(fold_sum[FOLD_SHIFT +: TRYTE_W] * TRYTE_WRAP);
    wrap = rem > TRYTE_HALF;
    res_o.quot  = VALUE_W'(fold_sum[SUM_W-1:FOLD_SHIFT]);
    res_o.carry = wrap;
    res_o.digit = tryte_t'(wrap ? TRYTE_W'(rem + TRYTE_WRAP) : rem);
  end

endmodule
